/* design/oora_pkg.sv */
package oora_pkg;

   // alarm level, one-hot
   typedef enum logic [3:0] {
      LV_NORMAL = 4'b0001,
      LV_HIGH   = 4'b0010,
      LV_LOW    = 4'b0100,
      LV_FAULT  = 4'b1000
   } level_type;

   typedef enum logic [2:0] {
      NK_TO_NORMAL = 3'd0,
      NK_TO_HIGH   = 3'd1,
      NK_TO_LOW    = 3'd2,
      NK_TO_FAULT  = 3'd3,
      NK_ESCALATE  = 3'd4,
      NK_ACKED     = 3'd5
   } note_kind_type;

   localparam logic [2:0] CMD_SAMPLE    = 3'd0;
   localparam logic [2:0] CMD_TICK      = 3'd1;
   localparam logic [2:0] CMD_ACK       = 3'd2;
   localparam logic [2:0] CMD_MAINT_ON  = 3'd3;
   localparam logic [2:0] CMD_MAINT_OFF = 3'd4;

   localparam logic [2:0] REG_HIGH_LIMIT      = 3'd0;
   localparam logic [2:0] REG_LOW_LIMIT       = 3'd1;
   localparam logic [2:0] REG_DEADBAND        = 3'd2;
   localparam logic [2:0] REG_DELAY           = 3'd3;
   localparam logic [2:0] REG_DELAY_TO_NORMAL = 3'd4;
   localparam logic [2:0] REG_ESCALATE_AFTER  = 3'd5;

   localparam logic [31:0] TIME_ALL_ONES = 32'hFFFF_FFFF;

   localparam logic [1:0] CODE_NORMAL = 2'd0;
   localparam logic [1:0] CODE_HIGH   = 2'd1;
   localparam logic [1:0] CODE_LOW    = 2'd2;
   localparam logic [1:0] CODE_FAULT  = 2'd3;

   typedef struct packed {
      logic signed [31:0] hi_lim;
      logic signed [31:0] lo_lim;
      logic        [30:0] deadband;
      logic        [31:0] delay_s;
      logic        [31:0] delay_to_normal_s;
      logic        [31:0] esc_wait_s;
   } cfg_type;

   typedef struct packed {
      level_type          current_level;
      level_type          notified_level;
      logic               pending_valid;
      level_type          pending_level;
      logic        [31:0] pending_since;
      logic        [31:0] alarm_since;
      logic        [31:0] latest_time;
      logic signed [31:0] latest_value;
      logic               unacked;
      logic               escalated;
      logic               maintenance;
   } alarm_state_type;

   typedef struct packed {
      logic        [2:0]  command;
      logic        [31:0] now_s;
      logic signed [31:0] sample_value;
      logic               bad_read;
   } req_word_type;

   localparam cfg_type CFG_RESET = '{
      hi_lim:            32'sh7FFF_FFFF,
      lo_lim:            32'sh8000_0000,
      deadband:          31'd0,
      delay_s:           32'd0,
      delay_to_normal_s: TIME_ALL_ONES,
      esc_wait_s:        32'd0
   };

   localparam alarm_state_type STATE_RESET = '{
      current_level:  LV_NORMAL,
      notified_level: LV_NORMAL,
      pending_valid:  1'b0,
      pending_level:  LV_NORMAL,
      pending_since:  32'd0,
      alarm_since:    32'd0,
      latest_time:    32'd0,
      latest_value:   32'sd0,
      unacked:        1'b0,
      escalated:      1'b0,
      maintenance:    1'b0
   };

   function automatic logic [1:0] level_code(level_type lv);
      logic [1:0] code;
      unique case (lv)
         LV_NORMAL: code = CODE_NORMAL;
         LV_HIGH:   code = CODE_HIGH;
         LV_LOW:    code = CODE_LOW;
         LV_FAULT:  code = CODE_FAULT;
         default:   code = CODE_NORMAL;
      endcase
      return code;
   endfunction

   function automatic note_kind_type level_note(level_type lv);
      note_kind_type nk;
      unique case (lv)
         LV_NORMAL: nk = NK_TO_NORMAL;
         LV_HIGH:   nk = NK_TO_HIGH;
         LV_LOW:    nk = NK_TO_LOW;
         LV_FAULT:  nk = NK_TO_FAULT;
         default:   nk = NK_TO_NORMAL;
      endcase
      return nk;
   endfunction

endpackage

/* design/oora_step.sv */
module oora_step
   import oora_pkg::*;
#(
   parameter int MAX_NOTES = 3,
   localparam int NCW = $clog2(MAX_NOTES + 1),
   localparam int IW  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1
) (
   input  cfg_type                          cfg,
   input  alarm_state_type                  st,
   input  req_word_type                     word,
   output alarm_state_type                  st_next,
   output logic          [NCW-1:0]          note_cnt,
   output note_kind_type [MAX_NOTES-1:0]    note_kinds
);

   logic signed [32:0] x33, hi33, lo33, db33, hi_db, lo_db;
   logic               gt_hi, lt_lo, lt_hidb, gt_lodb;
   logic        [31:0] el_pend, el_alarm, dly;
   logic               cmd_known, time_back, go, is_sample, skip_eval;
   logic               fresh, due, tgt_ok, alarm_set;
   level_type          tgt;

   // limit compares in 33 bits, independent of level
   assign x33     = {word.sample_value[31], word.sample_value};
   assign hi33    = {cfg.hi_lim[31], cfg.hi_lim};
   assign lo33    = {cfg.lo_lim[31], cfg.lo_lim};
   assign db33    = {2'b00, cfg.deadband};
   assign hi_db   = hi33 - db33;
   assign lo_db   = lo33 + db33;
   assign gt_hi   = x33 > hi33;
   assign lt_lo   = x33 < lo33;
   assign lt_hidb = x33 < hi_db;
   assign gt_lodb = x33 > lo_db;

   assign el_pend  = word.now_s - st.pending_since;
   assign el_alarm = word.now_s - st.alarm_since;

   assign cmd_known = word.command <= CMD_MAINT_OFF;
   assign time_back = word.now_s < st.latest_time;
   assign go        = cmd_known && !time_back;
   assign is_sample = word.command == CMD_SAMPLE;
   assign skip_eval = is_sample && word.bad_read;

   function automatic void emit_note(inout note_kind_type [MAX_NOTES-1:0] k,
                                     inout logic [NCW-1:0] c,
                                     input note_kind_type nk);
      if (c < NCW'(MAX_NOTES)) begin
         k[c[IW-1:0]] = nk;
         c = c + NCW'(1);
      end
   endfunction

   function automatic void notify_level(inout alarm_state_type s,
                                        inout note_kind_type [MAX_NOTES-1:0] k,
                                        inout logic [NCW-1:0] c,
                                        inout logic aset,
                                        input logic [31:0] now);
      emit_note(k, c, level_note(s.current_level));
      s.notified_level = s.current_level;
      if (s.current_level == LV_HIGH || s.current_level == LV_LOW) begin
         s.unacked     = 1'b1;
         s.alarm_since = now;
         s.escalated   = 1'b0;
         aset          = 1'b1;
      end
   endfunction

   function automatic void go_to(inout alarm_state_type s,
                                 inout note_kind_type [MAX_NOTES-1:0] k,
                                 inout logic [NCW-1:0] c,
                                 inout logic aset,
                                 input level_type lv,
                                 input logic [31:0] now);
      s.current_level = lv;
      s.pending_valid = 1'b0;
      if (!s.maintenance) begin
         notify_level(s, k, c, aset, now);
      end
   endfunction

   always_comb begin
      st_next   = st;
      note_cnt  = '0;
      for (int i = 0; i < MAX_NOTES; i++) begin
         note_kinds[i] = NK_TO_NORMAL;
      end
      alarm_set = 1'b0;
      fresh     = 1'b0;
      due       = 1'b0;
      dly       = cfg.delay_s;
      tgt_ok    = 1'b0;
      tgt       = LV_NORMAL;

      if (go) begin
         st_next.latest_time = word.now_s;

         if (is_sample) begin
            st_next.latest_value = word.sample_value;
            if (word.bad_read) begin
               if (st_next.current_level != LV_FAULT) begin
                  go_to(st_next, note_kinds, note_cnt, alarm_set, LV_FAULT, word.now_s);
               end
               st_next.pending_valid = 1'b0;
            end else begin
               if (st_next.current_level == LV_FAULT) begin
                  go_to(st_next, note_kinds, note_cnt, alarm_set, LV_NORMAL, word.now_s);
               end
               unique case (st_next.current_level)
                  LV_NORMAL: begin
                     if (gt_hi) begin
                        tgt_ok = 1'b1; tgt = LV_HIGH;
                     end else if (lt_lo) begin
                        tgt_ok = 1'b1; tgt = LV_LOW;
                     end
                  end
                  LV_HIGH: begin
                     if (lt_lo) begin
                        tgt_ok = 1'b1; tgt = LV_LOW;
                     end else if (lt_hidb) begin
                        tgt_ok = 1'b1; tgt = LV_NORMAL;
                     end
                  end
                  LV_LOW: begin
                     if (gt_hi) begin
                        tgt_ok = 1'b1; tgt = LV_HIGH;
                     end else if (gt_lodb) begin
                        tgt_ok = 1'b1; tgt = LV_NORMAL;
                     end
                  end
                  default: ;
               endcase
               if (!tgt_ok) begin
                  st_next.pending_valid = 1'b0;
               end else if (!st_next.pending_valid || tgt != st_next.pending_level) begin
                  st_next.pending_valid = 1'b1;
                  st_next.pending_level = tgt;
                  st_next.pending_since = word.now_s;
                  fresh                 = 1'b1;
               end
            end
         end

         // pending transition; a freshly started one has zero elapsed time
         if (!skip_eval && st_next.current_level != LV_FAULT && st_next.pending_valid) begin
            if (st_next.pending_level == LV_NORMAL && cfg.delay_to_normal_s != TIME_ALL_ONES) begin
               dly = cfg.delay_to_normal_s;
            end
            due = fresh ? (dly == '0) : (el_pend >= dly);
            if (due) begin
               go_to(st_next, note_kinds, note_cnt, alarm_set, st_next.pending_level,
                     word.now_s);
            end
         end

         if (word.command == CMD_ACK && st_next.unacked) begin
            st_next.unacked = 1'b0;
            if (!st_next.maintenance) begin
               emit_note(note_kinds, note_cnt, NK_ACKED);
            end
         end
         if (word.command == CMD_MAINT_ON) begin
            st_next.maintenance = 1'b1;
         end
         if (word.command == CMD_MAINT_OFF && st_next.maintenance) begin
            st_next.maintenance = 1'b0;
            if (st_next.current_level != st_next.notified_level) begin
               notify_level(st_next, note_kinds, note_cnt, alarm_set, word.now_s);
            end
         end

         // alarm restarted this word means zero elapsed, never due
         if (st_next.unacked && !st_next.escalated && !st_next.maintenance &&
             cfg.esc_wait_s != '0 && !alarm_set &&
             el_alarm >= cfg.esc_wait_s) begin
            emit_note(note_kinds, note_cnt, NK_ESCALATE);
            st_next.escalated = 1'b1;
         end
      end
   end

endmodule

/* design/oora_note_q.sv */
module oora_note_q
   import oora_pkg::*;
#(
   parameter int MAX_NOTES = 3,
   localparam int NCW = $clog2(MAX_NOTES + 1),
   localparam int IW  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic          [NCW-1:0]       push_cnt,
   input  note_kind_type [MAX_NOTES-1:0] push_kinds,
   input  logic          [31:0]          push_stamp,
   input  logic signed   [31:0]          push_value,
   input  logic          [1:0]           push_level,
   output logic                          full,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic          [2:0]           rsp_note_kind,
   output logic          [31:0]          rsp_note_stamp,
   output logic signed   [31:0]          rsp_note_value,
   output logic          [1:0]           rsp_level_after,
   output logic                          rsp_last_note
);

   localparam int QDEPTH = 2;
   localparam int PW     = $clog2(QDEPTH);
   localparam int FW     = $clog2(QDEPTH + 1);

   // one entry per word, its notes drained in order
   note_kind_type [MAX_NOTES-1:0] kinds_ff [QDEPTH];
   logic          [NCW-1:0]       cnt_ff   [QDEPTH];
   logic          [31:0]          stamp_ff [QDEPTH];
   logic signed   [31:0]          value_ff [QDEPTH];
   logic          [1:0]           level_ff [QDEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          pop_note, pop_item;

   assign full            = fill_ff == FW'(QDEPTH);
   assign rsp_valid       = fill_ff != '0;
   assign rsp_note_kind   = kinds_ff[rd_ptr_ff][idx_ff];
   assign rsp_note_stamp  = stamp_ff[rd_ptr_ff];
   assign rsp_note_value  = value_ff[rd_ptr_ff];
   assign rsp_level_after = level_ff[rd_ptr_ff];
   assign rsp_last_note   = (NCW'(idx_ff) + NCW'(1)) == cnt_ff[rd_ptr_ff];

   assign pop_note = rsp_valid && rsp_ready;
   assign pop_item = pop_note && rsp_last_note;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop_item ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop_item) begin
         fill_in = fill_ff + FW'(1);
      end else if (!push && pop_item) begin
         fill_in = fill_ff - FW'(1);
      end
      if (pop_item) begin
         idx_in = '0;
      end else if (pop_note) begin
         idx_in = idx_ff + IW'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         idx_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kinds_ff[wr_ptr_ff] <= push_kinds;
         cnt_ff[wr_ptr_ff]   <= push_cnt;
         stamp_ff[wr_ptr_ff] <= push_stamp;
         value_ff[wr_ptr_ff] <= push_value;
         level_ff[wr_ptr_ff] <= push_level;
      end
   end

endmodule

/* design/out_of_range_alarm_fsm.sv */
// Path: from accepting a word, its first note passes the input register, then the note queue
// register, before it can be taken.
// Throughput: one word per cycle while the note queue has room; the result channel moves
// one note per cycle while rsp_ready is high, and the input stalls once the two-entry
// note queue is full.
// Reset: synchronous, clears config, alarm state, word valid and queue pointers at once.
module out_of_range_alarm_fsm
   import oora_pkg::*;
#(
   parameter int MAX_NOTES = 3,
   localparam int NCW = $clog2(MAX_NOTES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic        [2:0]  req_command,
   input  logic        [31:0] req_now_s,
   input  logic signed [31:0] req_sample_value,
   input  logic               req_bad_read,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [2:0]  rsp_note_kind,
   output logic        [31:0] rsp_note_stamp,
   output logic signed [31:0] rsp_note_value,
   output logic        [1:0]  rsp_level_after,
   output logic               rsp_last_note,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [2:0]  csr_index,
   input  logic        [31:0] csr_data
);

   cfg_type         cfg_ff, cfg_in;
   req_word_type    word_ff, word_in;
   logic            word_valid_ff, word_valid_in;
   alarm_state_type state_ff, state_in;

   alarm_state_type               st_next;
   logic          [NCW-1:0]       note_cnt;
   note_kind_type [MAX_NOTES-1:0] note_kinds;
   logic                          q_full, advance, req_take, push;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_HIGH_LIMIT:      cfg_in.hi_lim            = csr_data;
            REG_LOW_LIMIT:       cfg_in.lo_lim            = csr_data;
            REG_DEADBAND:        cfg_in.deadband          = csr_data[30:0];
            REG_DELAY:           cfg_in.delay_s           = csr_data;
            REG_DELAY_TO_NORMAL: cfg_in.delay_to_normal_s = csr_data;
            REG_ESCALATE_AFTER:  cfg_in.esc_wait_s        = csr_data;
            default: ;
         endcase
      end
   end

   assign advance   = word_valid_ff && !q_full;
   assign req_ready = !word_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign push      = advance && (note_cnt != '0);

   always_comb begin
      word_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : word_valid_ff);
      word_in       = req_take ? '{command:      req_command,
                                   now_s:        req_now_s,
                                   sample_value: req_sample_value,
                                   bad_read:     req_bad_read} : word_ff;
      state_in      = advance ? st_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= CFG_RESET;
         word_valid_ff <= 1'b0;
         state_ff      <= STATE_RESET;
      end else begin
         cfg_ff        <= cfg_in;
         word_valid_ff <= word_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   oora_step #(
      .MAX_NOTES (MAX_NOTES)
   ) u_step (
      .cfg        (cfg_ff),
      .st         (state_ff),
      .word       (word_ff),
      .st_next    (st_next),
      .note_cnt   (note_cnt),
      .note_kinds (note_kinds)
   );

   oora_note_q #(
      .MAX_NOTES (MAX_NOTES)
   ) u_note_q (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .push_cnt        (note_cnt),
      .push_kinds      (note_kinds),
      .push_stamp      (word_ff.now_s),
      .push_value      (st_next.latest_value),
      .push_level      (level_code(st_next.current_level)),
      .full            (q_full),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_note_kind   (rsp_note_kind),
      .rsp_note_stamp  (rsp_note_stamp),
      .rsp_note_value  (rsp_note_value),
      .rsp_level_after (rsp_level_after),
      .rsp_last_note   (rsp_last_note)
   );

endmodule

/* bench/tb_out_of_range_alarm_fsm.sv */
module tb_out_of_range_alarm_fsm;
   timeunit 1ns;
   timeprecision 1ps;

   import oora_pkg::*;

   localparam int MAX_NOTES = 3;
   localparam int QUIET_LIMIT = 1000;

   typedef struct {
      req_word_type w;
      bit           drain;
   } cmd_word_type;

   typedef struct {
      note_kind_type      kind;
      logic        [31:0] stamp;
      logic signed [31:0] value;
      logic        [1:0]  level;
      logic               last_flag;
   } note_rec_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic        [2:0]  req_command = '0;
   logic        [31:0] req_now_s = '0;
   logic signed [31:0] req_sample_value = '0;
   logic               req_bad_read = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic        [2:0]  rsp_note_kind;
   logic        [31:0] rsp_note_stamp;
   logic signed [31:0] rsp_note_value;
   logic        [1:0]  rsp_level_after;
   logic               rsp_last_note;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic        [2:0]  csr_index = '0;
   logic        [31:0] csr_data = '0;

   out_of_range_alarm_fsm #(.MAX_NOTES(MAX_NOTES)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_now_s        (req_now_s),
      .req_sample_value (req_sample_value),
      .req_bad_read     (req_bad_read),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_note_kind    (rsp_note_kind),
      .rsp_note_stamp   (rsp_note_stamp),
      .rsp_note_value   (rsp_note_value),
      .rsp_level_after  (rsp_level_after),
      .rsp_last_note    (rsp_last_note),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------- alarm predictor ----------------
   cfg_type            cfg_now = CFG_RESET;
   logic        [1:0]  lvl_now = CODE_NORMAL;
   logic        [1:0]  lvl_told = CODE_NORMAL;
   logic        [1:0]  pend_lvl = CODE_NORMAL;
   bit                 pend_on, unack, escal, maint;
   logic        [31:0] pend_t0 = '0;
   logic        [31:0] alarm_t0 = '0;
   logic        [31:0] last_t = '0;
   logic signed [31:0] last_v = '0;

   note_kind_type step_notes[$];
   note_rec_type  awaited_notes[$];
   cmd_word_type  cmd_words[$];
   int            errors = 0;
   int            words_queued = 0;
   int            words_taken = 0;

   function automatic void note_out(note_kind_type k);
      if (step_notes.size() < MAX_NOTES)
         step_notes.push_back(k);
   endfunction

   function automatic void announce(logic [31:0] t);
      note_out(note_kind_type'({1'b0, lvl_now}));
      lvl_told = lvl_now;
      if (lvl_now == CODE_HIGH || lvl_now == CODE_LOW) begin
         unack = 1'b1;
         alarm_t0 = t;
         escal = 1'b0;
      end
   endfunction

   function automatic void move_to(logic [1:0] lv, logic [31:0] t);
      lvl_now = lv;
      pend_on = 1'b0;
      if (!maint)
         announce(t);
   endfunction

   // limits compared in 33 bits so hi - deadband / lo + deadband cannot wrap
   function automatic bit pick_target(input logic signed [31:0] v, output logic [1:0] lv);
      logic signed [32:0] x, hi, lo, dbx;
      bit hit;
      x = v;
      hi = $signed(cfg_now.hi_lim);
      lo = $signed(cfg_now.lo_lim);
      dbx = $signed({2'b00, cfg_now.deadband});
      hit = 1'b1;
      lv = CODE_NORMAL;
      case (lvl_now)
         CODE_NORMAL: begin
            if (x > hi) lv = CODE_HIGH;
            else if (x < lo) lv = CODE_LOW;
            else hit = 1'b0;
         end
         CODE_HIGH: begin
            if (x < lo) lv = CODE_LOW;
            else if (x < hi - dbx) lv = CODE_NORMAL;
            else hit = 1'b0;
         end
         CODE_LOW: begin
            if (x > hi) lv = CODE_HIGH;
            else if (x > lo + dbx) lv = CODE_NORMAL;
            else hit = 1'b0;
         end
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic void run_pending(logic [31:0] t);
      logic [31:0] d;
      if (lvl_now == CODE_FAULT || !pend_on)
         return;
      d = cfg_now.delay_s;
      if (pend_lvl == CODE_NORMAL && cfg_now.delay_to_normal_s != TIME_ALL_ONES)
         d = cfg_now.delay_to_normal_s;
      if (t - pend_t0 >= d)
         move_to(pend_lvl, t);
   endfunction

   function automatic void alarm_notes_for(req_word_type w);
      logic [1:0]  tgt;
      logic [31:0] t;
      note_rec_type n;
      step_notes.delete();
      t = w.now_s;
      if (w.command > CMD_MAINT_OFF || t < last_t)
         return;
      last_t = t;
      case (w.command)
         CMD_SAMPLE: begin
            last_v = w.sample_value;
            if (w.bad_read) begin
               if (lvl_now != CODE_FAULT)
                  move_to(CODE_FAULT, t);
               pend_on = 1'b0;
            end else begin
               if (lvl_now == CODE_FAULT)
                  move_to(CODE_NORMAL, t);
               if (!pick_target(w.sample_value, tgt)) begin
                  pend_on = 1'b0;
               end else if (!pend_on || tgt != pend_lvl) begin
                  pend_on = 1'b1;
                  pend_lvl = tgt;
                  pend_t0 = t;
               end
               run_pending(t);
            end
         end
         CMD_TICK: run_pending(t);
         CMD_ACK: begin
            run_pending(t);
            if (unack) begin
               unack = 1'b0;
               if (!maint)
                  note_out(NK_ACKED);
            end
         end
         CMD_MAINT_ON: begin
            run_pending(t);
            maint = 1'b1;
         end
         default: begin
            run_pending(t);
            if (maint) begin
               maint = 1'b0;
               if (lvl_now != lvl_told)
                  announce(t);
            end
         end
      endcase
      if (unack && !escal && !maint && cfg_now.esc_wait_s != 0 &&
          t - alarm_t0 >= cfg_now.esc_wait_s) begin
         note_out(NK_ESCALATE);
         escal = 1'b1;
      end
      foreach (step_notes[k]) begin
         n.kind = step_notes[k];
         n.stamp = t;
         n.value = last_v;
         n.level = lvl_now;
         n.last_flag = (k == step_notes.size() - 1);
         awaited_notes.push_back(n);
      end
   endfunction

   // ---------------- command driver ----------------
   int           send_gap = 0;
   bit           send_idle = 1'b0;
   cmd_word_type next_word;
   req_word_type cur_word;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            alarm_notes_for(cur_word);
            words_taken++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (cmd_words.size() != 0 &&
                         !(cmd_words[0].drain && awaited_notes.size() != 0)) begin
               next_word = cmd_words.pop_front();
               cur_word <= next_word.w;
               req_command <= next_word.w.command;
               req_now_s <= next_word.w.now_s;
               req_sample_value <= next_word.w.sample_value;
               req_bad_read <= next_word.w.bad_read;
               req_valid <= 1'b1;
               send_gap <= send_idle ? int'($urandom_range(0, 5)) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- note monitor ----------------
   int recv_gap = 0;
   int stall_draw;
   bit recv_idle = 1'b0;
   note_rec_type got_note;

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (awaited_notes.size() == 0) begin
            $error("note_kind: expected none, got 0x%0h", rsp_note_kind);
            errors++;
         end else begin
            got_note = awaited_notes.pop_front();
            check_field("note_kind", 32'(got_note.kind), 32'(rsp_note_kind));
            check_field("note_stamp", got_note.stamp, rsp_note_stamp);
            check_field("note_value", got_note.value, rsp_note_value);
            check_field("level_after", 32'(got_note.level), 32'(rsp_level_after));
            check_field("last_note", 32'(got_note.last_flag), 32'(rsp_last_note));
         end
         stall_draw = recv_idle ? int'($urandom_range(0, 5)) : 0;
         recv_gap <= stall_draw;
         rsp_ready <= (stall_draw == 0);
      end else if (recv_gap != 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= (recv_gap == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------- watchdog ----------------
   int quiet = 0;

   always @(posedge clock) begin
      if (reset) begin
         quiet <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                   (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // ---------------- stimulus ----------------
   logic [31:0] gen_now = '0;

   function automatic logic [31:0] step_time(logic [31:0] dt);
      if (dt > TIME_ALL_ONES - gen_now) gen_now = TIME_ALL_ONES;
      else gen_now = gen_now + dt;
      return gen_now;
   endfunction

   task automatic put_word(logic [2:0] cmd, logic [31:0] t, logic signed [31:0] v,
                           bit flt, bit drain);
      cmd_word_type p;
      p.w.command = cmd;
      p.w.now_s = t;
      p.w.sample_value = v;
      p.w.bad_read = flt;
      p.drain = drain;
      cmd_words.push_back(p);
      words_queued++;
   endtask

   // values cluster around the thresholds and zero, with some fully random
   function automatic logic signed [31:0] pick_value();
      logic signed [33:0] base, v;
      int off;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: base = $signed(cfg_now.hi_lim);
         2: base = $signed(cfg_now.lo_lim);
         3: base = $signed(cfg_now.hi_lim) - $signed({1'b0, cfg_now.deadband});
         4: base = $signed(cfg_now.lo_lim) + $signed({1'b0, cfg_now.deadband});
         default: base = '0;
      endcase
      off = int'($urandom_range(0, 8)) - 4;
      off = off * (($urandom_range(0, 1) != 0) ? 1 : 65536);
      v = base + off;
      if (v > 34'sd2147483647) v = 34'sd2147483647;
      if (v < -34'sd2147483648) v = -34'sd2147483648;
      return v[31:0];
   endfunction

   task automatic random_words(int count);
      int unsigned r;
      logic [31:0] dt, back;
      logic [2:0] cmd;
      bit drain;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         dt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 3);
         drain = (i == 0) || ($urandom_range(0, 24) == 0);
         if (r < 55) cmd = CMD_SAMPLE;
         else if (r < 70) cmd = CMD_TICK;
         else if (r < 80) cmd = CMD_ACK;
         else if (r < 86) cmd = CMD_MAINT_ON;
         else if (r < 92) cmd = CMD_MAINT_OFF;
         else if (r < 96) cmd = CMD_TICK;
         else cmd = CMD_MAINT_OFF + 3'd1 + 3'($urandom_range(0, 2));
         if (r >= 92 && r < 96 && gen_now != 0) begin
            // stale time stamp, must be ignored
            back = $urandom_range(1, gen_now > 50 ? 50 : gen_now);
            put_word(3'($urandom_range(CMD_SAMPLE, CMD_MAINT_OFF)), gen_now - back,
                     pick_value(), $urandom_range(0, 1), drain);
         end else begin
            put_word(cmd, step_time(dt), pick_value(), $urandom_range(0, 19) == 0, drain);
         end
      end
   endtask

   task automatic settle();
      while (words_taken != words_queued || awaited_notes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_HIGH_LIMIT:      cfg_now.hi_lim = data;
         REG_LOW_LIMIT:       cfg_now.lo_lim = data;
         REG_DEADBAND:        cfg_now.deadband = data[30:0];
         REG_DELAY:           cfg_now.delay_s = data;
         REG_DELAY_TO_NORMAL: cfg_now.delay_to_normal_s = data;
         REG_ESCALATE_AFTER:  cfg_now.esc_wait_s = data;
         default: ;
      endcase
   endtask

   task automatic apply_setup(logic [31:0] hi, logic [31:0] lo, logic [31:0] db,
                              logic [31:0] dl, logic [31:0] dn, logic [31:0] es);
      write_reg(REG_HIGH_LIMIT, hi);
      write_reg(REG_LOW_LIMIT, lo);
      write_reg(REG_DEADBAND, db);
      write_reg(REG_DELAY, dl);
      write_reg(REG_DELAY_TO_NORMAL, dn);
      write_reg(REG_ESCALATE_AFTER, es);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: widest limits, so only fault moves the level
      send_idle = 1'b1;
      recv_idle = 1'b1;
      put_word(CMD_SAMPLE, step_time(0), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_SAMPLE, step_time(1), 32'sh7FFF_FFFF, 1'b0, 1'b0);
      put_word(CMD_SAMPLE, step_time(0), 32'sh8000_0000, 1'b0, 1'b0);
      put_word(CMD_SAMPLE, step_time(1), 32'sh0001_8000, 1'b1, 1'b0);
      put_word(CMD_TICK, step_time(0), 32'sh7FFF_FFFF, 1'b1, 1'b0);
      put_word(CMD_SAMPLE, step_time(1), 32'sh0003_0000, 1'b0, 1'b0);
      put_word(CMD_MAINT_OFF + 3'd3, step_time(0), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_ACK, step_time(1), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_MAINT_ON, step_time(1), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_SAMPLE, step_time(0), -32'sd1, 1'b1, 1'b0);
      put_word(CMD_MAINT_OFF, step_time(1), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_SAMPLE, step_time(0), 32'sd0, 1'b0, 1'b1);
      put_word(CMD_SAMPLE, 32'd2, 32'sh0100_0000, 1'b1, 1'b0);
      settle();

      // +/-100.0 limits, 5.0 deadband, no delay back to normal
      apply_setup(32'h0064_0000, 32'hFF9C_0000, 32'h0005_0000, 32'd3, 32'd0, 32'd4);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      put_word(CMD_SAMPLE, step_time(3), 32'sh00C8_0000, 1'b0, 1'b0);
      put_word(CMD_TICK, step_time(2), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_TICK, step_time(1), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_TICK, step_time(4), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_ACK, step_time(1), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_SAMPLE, step_time(1), 32'shFF38_0000, 1'b0, 1'b0);
      put_word(CMD_TICK, step_time(3), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_SAMPLE, step_time(1), 32'shFF9F_0000, 1'b0, 1'b0);
      put_word(CMD_SAMPLE, step_time(1), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_TICK, step_time(5), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_SAMPLE, step_time(1), 32'sd0, 1'b1, 1'b1);
      random_words(30);
      settle();

      apply_setup($urandom_range(0, 200) << 16, 32'hFFFF_FFFF - ($urandom_range(0, 200) << 16),
                   ($urandom_range(0, 10) << 16) | $urandom_range(0, 65535),
                   $urandom_range(0, 5),
                   ($urandom_range(0, 1) != 0) ? TIME_ALL_ONES : $urandom_range(0, 5),
                   $urandom_range(0, 10));
      send_idle = 1'b1;
      recv_idle = 1'b1;
      random_words(30);
      settle();

      // inverted extreme limits, widest deadband (bit 31 of the write is dropped)
      apply_setup(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1);
      send_idle = 1'b1;
      recv_idle = 1'b0;
      random_words(30);
      settle();

      apply_setup($urandom_range(0, 20) << 16, 32'hFFFF_FFFF - ($urandom_range(0, 20) << 16),
                   $urandom_range(0, 3) << 16, $urandom_range(0, 3), TIME_ALL_ONES,
                   $urandom_range(1, 8));
      send_idle = 1'b0;
      recv_idle = 1'b1;
      random_words(30);
      settle();

      // longest delay and escalation wait, then time runs to the top of its range
      apply_setup(32'h0005_0000, 32'hFFFB_0000, 32'd0, TIME_ALL_ONES, 32'd2, TIME_ALL_ONES);
      send_idle = 1'b1;
      recv_idle = 1'b1;
      random_words(10);
      put_word(CMD_TICK, step_time(32'hFFFF_0000 - gen_now), 32'sd0, 1'b0, 1'b0);
      random_words(20);
      put_word(CMD_TICK, step_time(TIME_ALL_ONES), 32'sd0, 1'b0, 1'b0);
      put_word(CMD_SAMPLE, TIME_ALL_ONES, 32'sh7FFF_FFFF, 1'b0, 1'b0);
      settle();

      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* out_of_range_alarm_fsm.f */
design/oora_pkg.sv
design/oora_step.sv
design/oora_note_q.sv
design/out_of_range_alarm_fsm.sv
bench/tb_out_of_range_alarm_fsm.sv
